@@ src/logo_source_tokenizer_core_macros.svh @@
// Assertion macros for the logo source tokenizer.
// Included by modules that check their own logic; no other dependencies.
`ifndef LOGO_SOURCE_TOKENIZER_CORE_MACROS_SVH
`define LOGO_SOURCE_TOKENIZER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every rising clock edge outside reset.
`define LST_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("lst assertion failed");
// Condition must never be true outside reset.
`define LST_NEVER(lbl, clk, rstn, cond) \
  `LST_ASSERT(lbl, clk, rstn, !(cond))
`else
`define LST_ASSERT(lbl, clk, rstn, prop)
`define LST_NEVER(lbl, clk, rstn, cond)
`endif

`endif

@@ src/lst_pkg.sv @@
// Shared types and constants for the logo source tokenizer.
// No dependencies; used by the front, queue, back and top modules.
package lst_pkg;

  localparam int unsigned TOK_POS_W = 16;
  localparam int unsigned CHAR_W    = 8;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;  // ;
  localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3A;  // :
  localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h22;  // "
  localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;  // .
  localparam logic [CHAR_W-1:0] CH_NL     = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_LBRK   = 8'h5B;  // [
  localparam logic [CHAR_W-1:0] CH_RBRK   = 8'h5D;  // ]
  localparam logic [CHAR_W-1:0] CH_LPAR   = 8'h28;  // (
  localparam logic [CHAR_W-1:0] CH_RPAR   = 8'h29;  // )
  localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_LT     = 8'h3C;
  localparam logic [CHAR_W-1:0] CH_GT     = 8'h3E;
  localparam logic [CHAR_W-1:0] CH_EQ     = 8'h3D;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;

  typedef enum logic [3:0] {
    KIND_NUMBER = 4'd0,
    KIND_WORD   = 4'd1,
    KIND_QWORD  = 4'd2,
    KIND_VAR    = 4'd3,
    KIND_LBRK   = 4'd4,
    KIND_RBRK   = 4'd5,
    KIND_LPAR   = 4'd6,
    KIND_RPAR   = 4'd7,
    KIND_OP     = 4'd8
  } kind_e;

  typedef enum logic [6:0] {
    MODE_IDLE    = 7'b0000001,
    MODE_NUMBER  = 7'b0000010,
    MODE_WORD    = 7'b0000100,
    MODE_QWORD   = 7'b0001000,
    MODE_VAR     = 7'b0010000,
    MODE_DOT     = 7'b0100000,
    MODE_COMMENT = 7'b1000000
  } mode_e;

  typedef struct packed {
    kind_e                kind;
    logic [TOK_POS_W-1:0] start;
    logic [TOK_POS_W-1:0] length;
    logic [CHAR_W-1:0]    chr;
  } token_t;

  // Tokens caused by one character: one or two.
  typedef struct packed {
    logic   two;
    token_t tok0;
    token_t tok1;
  } run_t;

endpackage

@@ src/logo_source_tokenizer_core.sv @@
// Logo source tokenizer: character stream in, token stream out.
// Input side is a queue write port: a character beat (ch_i, end_of_source_i)
// is taken at a clock edge with push high and full low.
// Output side is a queue read port: while empty is low the oldest token sits
// on the token_* ports; it is taken at a clock edge with pop high.
// Throughput: one character per cycle while full is low; a character that
// closes a token and forms a single-character one (or opens one flushed at
// end of source) yields two token beats, and the output side then drains
// one token per cycle while pop is high.
// The front end holds the lexer state and turns each character into a run of
// one or two tokens; a QUEUE_DEPTH-entry run queue decouples it from the back
// end, which hands out the tokens of a run one by one (last_of_run_o marks
// the final one). When pop stays low the queue fills and full rises; pushing
// then waits, nothing is dropped.
// Reset: queue empty, lexer idle, position and token start at offset 0.
// end_of_source_i flushes the open token and restarts offsets at 0.
// Positions saturate at 2**POSITION_BITS-1; ports carry the low 16 bits.
// Depends on lst_pkg, lst_front, lst_queue, lst_back and the macro header.
`include "logo_source_tokenizer_core_macros.svh"

module logo_source_tokenizer_core #(
  parameter int unsigned POSITION_BITS = 16,
  parameter int unsigned QUEUE_DEPTH   = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  ch_i,
  input  logic        end_of_source_i,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  token_kind_o,
  output logic [15:0] token_start_o,
  output logic [15:0] token_length_o,
  output logic [7:0]  token_char_o,
  output logic        last_of_run_o
);

  logic            accept;     // input beat taken
  logic            run_valid;  // front produced at least one token
  lst_pkg::run_t   run_in;
  lst_pkg::run_t   run_head;
  logic            head_rd;    // back retires the head run
  lst_pkg::token_t tok;

  assign accept = push && !full;

  lst_front #(
    .PosBits(POSITION_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .ch_i       (ch_i),
    .eos_i      (end_of_source_i),
    .run_valid_o(run_valid),
    .run_o      (run_in)
  );

  // Full blocks pushes, so a produced run always finds a slot
  lst_queue #(
    .Depth(QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (run_valid),
    .wr_run_i(run_in),
    .rd_i    (head_rd),
    .rd_run_o(run_head),
    .full_o  (full),
    .empty_o (empty)
  );

  lst_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (run_head),
    .head_empty_i(empty),
    .pop_i       (pop),
    .head_rd_o   (head_rd),
    .tok_o       (tok),
    .last_o      (last_of_run_o)
  );

  assign token_kind_o   = tok.kind;
  assign token_start_o  = tok.start;
  assign token_length_o = tok.length;
  assign token_char_o   = tok.chr;

  // A full queue holds runs, so tokens are waiting
  `LST_ASSERT(a_full_has_tokens, clk_i, rst_ni, full |-> !empty)
  // Popping the first token of a two-token run leaves the second one up next
  `LST_ASSERT(a_run_second_last, clk_i, rst_ni, (pop && !empty && !last_of_run_o) |=> (!empty && last_of_run_o))
  // Tokens only appear after a character beat
  `LST_ASSERT(a_no_token_from_nothing, clk_i, rst_ni, (empty && !push) |=> empty)

endmodule

@@ src/lst_front.sv @@
// Front end: classifies each accepted character and runs the lexer state.
// Emits a run of one or two tokens for each character that produces any. Uses lst_pkg.
module lst_front #(
  parameter int unsigned PosBits = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  logic [7:0]             ch_i,
  input  logic                   eos_i,
  output logic                   run_valid_o,
  output lst_pkg::run_t          run_o
);

  localparam logic [PosBits-1:0] PosMax = {PosBits{1'b1}};

  lst_pkg::mode_e     mode_q, mode_d;
  logic [PosBits-1:0] begin_q, begin_d;
  logic [PosBits-1:0] pos_q, pos_d;

  logic               taken, cont;
  logic               tok_a_v, tok_i_v, tok_e_v;
  lst_pkg::token_t    tok_a, tok_i, tok_e;
  lst_pkg::mode_e     m;
  logic [PosBits:0]   eos_to, eos_from, eos_diff;
  logic [PosBits-1:0] eos_len;

  function automatic logic is_blank(input logic [7:0] c);
    return c == lst_pkg::CH_SPACE || c == lst_pkg::CH_TAB ||
           c == lst_pkg::CH_CR    || c == lst_pkg::CH_NL;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= lst_pkg::CH_ZERO && c <= lst_pkg::CH_NINE;
  endfunction

  function automatic logic is_op(input logic [7:0] c);
    return c == lst_pkg::CH_PLUS || c == lst_pkg::CH_MINUS ||
           c == lst_pkg::CH_STAR || c == lst_pkg::CH_SLASH ||
           c == lst_pkg::CH_LT   || c == lst_pkg::CH_GT    || c == lst_pkg::CH_EQ;
  endfunction

  function automatic logic is_delim(input logic [7:0] c);
    return is_blank(c) || is_op(c) ||
           c == lst_pkg::CH_LBRK || c == lst_pkg::CH_RBRK ||
           c == lst_pkg::CH_LPAR || c == lst_pkg::CH_RPAR ||
           c == lst_pkg::CH_SEMI || c == lst_pkg::CH_QUOTE || c == lst_pkg::CH_COLON;
  endfunction

  function automatic logic is_open(input lst_pkg::mode_e md);
    return md == lst_pkg::MODE_NUMBER || md == lst_pkg::MODE_WORD ||
           md == lst_pkg::MODE_QWORD  || md == lst_pkg::MODE_VAR;
  endfunction

  function automatic lst_pkg::kind_e kind_of(input lst_pkg::mode_e md);
    lst_pkg::kind_e k;
    unique case (md)
      lst_pkg::MODE_NUMBER: k = lst_pkg::KIND_NUMBER;
      lst_pkg::MODE_QWORD:  k = lst_pkg::KIND_QWORD;
      lst_pkg::MODE_VAR:    k = lst_pkg::KIND_VAR;
      default:              k = lst_pkg::KIND_WORD;
    endcase
    return k;
  endfunction

  function automatic logic [PosBits-1:0] sat_inc(input logic [PosBits-1:0] v);
    return (v == PosMax) ? v : v + PosBits'(1);
  endfunction

  function automatic lst_pkg::token_t mk_tok(input lst_pkg::kind_e k,
                                             input logic [PosBits-1:0] s,
                                             input logic [PosBits-1:0] l,
                                             input logic [7:0] c);
    lst_pkg::token_t t;
    t.kind   = k;
    t.start  = lst_pkg::TOK_POS_W'(s);
    t.length = lst_pkg::TOK_POS_W'(l);
    t.chr    = c;
    return t;
  endfunction

  always_comb begin
    taken   = 1'b0;
    cont    = 1'b0;
    m       = mode_q;
    begin_d = begin_q;
    tok_a_v = 1'b0;
    tok_i_v = 1'b0;
    tok_e_v = 1'b0;
    tok_a   = '0;
    tok_i   = '0;
    tok_e   = '0;

    // Modes that look at the character before the token logic
    unique case (mode_q)
      lst_pkg::MODE_COMMENT: begin
        if (ch_i == lst_pkg::CH_NL) m = lst_pkg::MODE_IDLE;
        taken = 1'b1;
      end
      lst_pkg::MODE_DOT: begin
        if (is_digit(ch_i)) begin
          m     = lst_pkg::MODE_NUMBER;
          taken = 1'b1;
        end else begin
          m = lst_pkg::MODE_WORD;
        end
      end
      lst_pkg::MODE_IDLE, lst_pkg::MODE_NUMBER, lst_pkg::MODE_WORD,
      lst_pkg::MODE_QWORD, lst_pkg::MODE_VAR: m = mode_q;
      default: m = lst_pkg::MODE_IDLE;
    endcase

    // Continue or close the open token
    if (!taken && is_open(m)) begin
      cont = (m == lst_pkg::MODE_NUMBER) ? (is_digit(ch_i) || ch_i == lst_pkg::CH_DOT)
                                         : !is_delim(ch_i);
      if (cont) begin
        taken = 1'b1;
      end else begin
        tok_a_v = 1'b1;
        tok_a   = mk_tok(kind_of(m), begin_q,
                         (pos_q > begin_q) ? pos_q - begin_q : '0, 8'h00);
        m       = lst_pkg::MODE_IDLE;
      end
    end

    // Character handled from idle (also a closing character)
    if (!taken) begin
      priority if (is_blank(ch_i)) begin
        m = lst_pkg::MODE_IDLE;
      end else if (ch_i == lst_pkg::CH_SEMI) begin
        m = lst_pkg::MODE_COMMENT;
      end else if (ch_i == lst_pkg::CH_LBRK) begin
        tok_i_v = 1'b1;
        tok_i   = mk_tok(lst_pkg::KIND_LBRK, pos_q, PosBits'(1), ch_i);
      end else if (ch_i == lst_pkg::CH_RBRK) begin
        tok_i_v = 1'b1;
        tok_i   = mk_tok(lst_pkg::KIND_RBRK, pos_q, PosBits'(1), ch_i);
      end else if (ch_i == lst_pkg::CH_LPAR) begin
        tok_i_v = 1'b1;
        tok_i   = mk_tok(lst_pkg::KIND_LPAR, pos_q, PosBits'(1), ch_i);
      end else if (ch_i == lst_pkg::CH_RPAR) begin
        tok_i_v = 1'b1;
        tok_i   = mk_tok(lst_pkg::KIND_RPAR, pos_q, PosBits'(1), ch_i);
      end else if (is_op(ch_i)) begin
        tok_i_v = 1'b1;
        tok_i   = mk_tok(lst_pkg::KIND_OP, pos_q, PosBits'(1), ch_i);
      end else if (ch_i == lst_pkg::CH_QUOTE) begin
        m       = lst_pkg::MODE_QWORD;
        begin_d = sat_inc(pos_q);
      end else if (ch_i == lst_pkg::CH_COLON) begin
        m       = lst_pkg::MODE_VAR;
        begin_d = sat_inc(pos_q);
      end else if (is_digit(ch_i)) begin
        m       = lst_pkg::MODE_NUMBER;
        begin_d = pos_q;
      end else if (ch_i == lst_pkg::CH_DOT) begin
        m       = lst_pkg::MODE_DOT;
        begin_d = pos_q;
      end else begin
        m       = lst_pkg::MODE_WORD;
        begin_d = pos_q;
      end
    end

    // End of source flush; span to p+1 saturates
    eos_to   = {1'b0, pos_q} + (PosBits+1)'(1);
    eos_from = {1'b0, begin_d};
    eos_diff = (eos_to > eos_from) ? eos_to - eos_from : '0;
    eos_len  = (eos_diff > {1'b0, PosMax}) ? PosMax : eos_diff[PosBits-1:0];

    if (eos_i) begin
      if (is_open(m)) begin
        tok_e_v = 1'b1;
        tok_e   = mk_tok(kind_of(m), begin_d, eos_len, 8'h00);
      end else if (m == lst_pkg::MODE_DOT) begin
        tok_e_v = 1'b1;
        tok_e   = mk_tok(lst_pkg::KIND_WORD, begin_d, PosBits'(1), 8'h00);
      end
      mode_d  = lst_pkg::MODE_IDLE;
      begin_d = '0;
      pos_d   = '0;
    end else begin
      mode_d = m;
      pos_d  = sat_inc(pos_q);
    end

    // Pack into a run, in order: close, single char, flush
    run_o.two  = (32'(tok_a_v) + 32'(tok_i_v) + 32'(tok_e_v)) == 32'd2;
    run_o.tok0 = tok_a_v ? tok_a : (tok_i_v ? tok_i : tok_e);
    run_o.tok1 = (tok_a_v && tok_i_v) ? tok_i : tok_e;
    run_valid_o = accept_i && (tok_a_v || tok_i_v || tok_e_v);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= lst_pkg::MODE_IDLE;
      begin_q <= '0;
      pos_q   <= '0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      begin_q <= begin_d;
      pos_q   <= pos_d;
    end
  end

endmodule

@@ src/lst_queue.sv @@
// Short run queue between the front end and the back end.
// Flip-flop storage, one write and one read per cycle. Uses lst_pkg.
module lst_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  lst_pkg::run_t wr_run_i,
  input  logic          rd_i,
  output lst_pkg::run_t rd_run_o,
  output logic          full_o,
  output logic          empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  lst_pkg::run_t       mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                do_wr, do_rd;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign full_o   = cnt_q == CntW'(Depth);
  assign empty_o  = cnt_q == '0;
  assign do_wr    = wr_i && !full_o;
  assign do_rd    = rd_i && !empty_o;
  assign rd_run_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_wr ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_rd ? ptr_next(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q + CntW'(do_wr) - CntW'(do_rd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_ptr_q] <= wr_run_i;
  end

endmodule

@@ src/lst_back.sv @@
// Back end: splits the run at the queue head into single token beats.
// Retires the run after its last token is popped. Uses lst_pkg.
module lst_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lst_pkg::run_t   head_i,
  input  logic            head_empty_i,
  input  logic            pop_i,
  output logic            head_rd_o,
  output lst_pkg::token_t tok_o,
  output logic            last_o
);

  logic sel_q, sel_d;
  logic beat;

  assign tok_o     = sel_q ? head_i.tok1 : head_i.tok0;
  assign last_o    = sel_q || !head_i.two;
  assign beat      = pop_i && !head_empty_i;
  assign head_rd_o = beat && last_o;

  always_comb begin
    sel_d = sel_q;
    if (beat) sel_d = !last_o;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
    end else begin
      sel_q <= sel_d;
    end
  end

endmodule
